// File: rtl/core/fpsl_pkg.sv
// ----------------------------------------------------------------------------
// fpsl_pkg
// Shared types and constants of the passive-serial FPGA loader.
// ----------------------------------------------------------------------------
package fpsl_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int QUEUE_DEPTH    = 2;

	// input item kinds (carried on tuser)
	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_BYTE  = 2'd2;
	localparam logic [1:0] MODE_END   = 2'd3;

	// sequence phases
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_PULSE   = 3'd1;
	localparam logic [2:0] PH_WAIT    = 3'd2;
	localparam logic [2:0] PH_LOAD    = 3'd3;
	localparam logic [2:0] PH_FINISH  = 3'd4;
	localparam logic [2:0] PH_DONE    = 3'd5;
	localparam logic [2:0] PH_TIMEOUT = 3'd6;
	localparam logic [2:0] PH_SPARE   = 3'd7;

	// nCONFIG pulse parts
	localparam logic [1:0] SUB_HIGH    = 2'd0;
	localparam logic [1:0] SUB_LOW     = 2'd1;
	localparam logic [1:0] SUB_RECOVER = 2'd2;
	localparam logic [1:0] SUB_END     = 2'd3;

	// back-end command kinds
	localparam logic [1:0] CMD_SINGLE = 2'd0;
	localparam logic [1:0] CMD_BYTE   = 2'd1;
	localparam logic [1:0] CMD_PULSE  = 2'd2;

	// register indexes
	localparam logic [1:0] REG_PULSE_HIGH  = 2'd0;
	localparam logic [1:0] REG_PULSE_LOW   = 2'd1;
	localparam logic [1:0] REG_RECOVER     = 2'd2;
	localparam logic [1:0] REG_DONE_TMO    = 2'd3;

	localparam logic [15:0] PULSE_HIGH_RST = 16'd11;
	localparam logic [15:0] PULSE_LOW_RST  = 16'd160;
	localparam logic [15:0] RECOVER_RST    = 16'd107;
	localparam logic [15:0] DONE_TMO_RST   = 16'd10000;

	// number of data bits in a bitstream byte, and last step of a byte burst and of a DCLK pulse
	localparam int          BYTE_BITS      = 8;
	localparam logic [4:0]  BYTE_LAST_STEP = 5'd16;
	localparam logic [4:0]  PULSE_LAST_STEP = 5'd1;

	typedef struct packed {
		logic [15:0] pulse_high_ticks;
		logic [15:0] pulse_low_ticks;
		logic [15:0] recover_ticks;
		logic [15:0] done_timeout;
	} cfg_t;

	// one unit of work for the back end: pin levels and phase after the item
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic       dclk;
		logic       data0;
		logic       nconfig;
		logic [2:0] phase;
	} cmd_t;

endpackage

// File: rtl/core/fpsl_front.sv
// ----------------------------------------------------------------------------
// fpsl_front
// Accepts input items, runs the sequence state and issues back-end commands.
// ----------------------------------------------------------------------------
module fpsl_front #(
	parameter int COUNT_BITS = fpsl_pkg::COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fpsl_pkg::cfg_t   cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       mode,
	input  logic [7:0]       data_byte,
	input  logic             nstatus_in,
	input  logic             conf_done_in,
	output logic             cmd_push,
	output fpsl_pkg::cmd_t   cmd,
	input  logic             queue_full
);

	localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	logic [2:0]            phase_q;
	logic [1:0]            sub_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  dclk_q;
	logic                  data0_q;
	logic                  nconfig_q;

	logic [2:0]            ph_n;
	logic [1:0]            sub_n;
	logic [COUNT_BITS-1:0] cnt_n;
	logic                  dclk_n;
	logic                  d0_n;
	logic                  nc_n;
	logic [1:0]            kind_n;
	logic                  accept;

	logic [COUNT_BITS-1:0] tgt_high;
	logic [COUNT_BITS-1:0] tgt_low;
	logic [COUNT_BITS-1:0] tgt_rec;
	logic [COUNT_BITS-1:0] tgt_tmo;

	// registers above the counter range act as the counter's largest value
	function automatic logic [COUNT_BITS-1:0] clip_f(input logic [15:0] v);
		logic [CW-1:0] ext;
		begin
			ext = CW'(v);
			if ((ext >> COUNT_BITS) != '0)
				clip_f = '1;
			else
				clip_f = ext[COUNT_BITS-1:0];
		end
	endfunction

	assign tgt_high = clip_f(cfg.pulse_high_ticks);
	assign tgt_low  = clip_f(cfg.pulse_low_ticks);
	assign tgt_rec  = clip_f(cfg.recover_ticks);
	assign tgt_tmo  = clip_f(cfg.done_timeout);

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign cmd_push = accept;

	always_comb begin
		logic                  settle;
		logic [COUNT_BITS-1:0] tgt;
		settle = 1'b0;
		tgt    = tgt_high;
		ph_n   = phase_q;
		sub_n  = sub_q;
		cnt_n  = cnt_q;
		dclk_n = dclk_q;
		d0_n   = data0_q;
		nc_n   = nconfig_q;
		kind_n = fpsl_pkg::CMD_SINGLE;

		if (mode == fpsl_pkg::MODE_START && (phase_q inside {fpsl_pkg::PH_IDLE,
				fpsl_pkg::PH_DONE, fpsl_pkg::PH_TIMEOUT, fpsl_pkg::PH_SPARE})) begin
			dclk_n = 1'b0;
			ph_n   = fpsl_pkg::PH_PULSE;
			sub_n  = fpsl_pkg::SUB_HIGH;
			cnt_n  = '0;
			settle = 1'b1;
		end else if (mode == fpsl_pkg::MODE_TICK && phase_q == fpsl_pkg::PH_PULSE) begin
			if (cnt_q != '1)
				cnt_n = cnt_q + 1'b1;
			settle = 1'b1;
		end else if (mode == fpsl_pkg::MODE_TICK && phase_q == fpsl_pkg::PH_WAIT) begin
			if (nstatus_in) begin
				ph_n  = fpsl_pkg::PH_LOAD;
				cnt_n = '0;
			end
		end else if (mode == fpsl_pkg::MODE_BYTE && phase_q == fpsl_pkg::PH_LOAD) begin
			kind_n = fpsl_pkg::CMD_BYTE;
			d0_n   = data_byte[fpsl_pkg::BYTE_BITS-1];
			dclk_n = 1'b0;
		end else if (mode == fpsl_pkg::MODE_END && phase_q == fpsl_pkg::PH_LOAD) begin
			ph_n  = fpsl_pkg::PH_FINISH;
			cnt_n = '0;
		end else if (mode == fpsl_pkg::MODE_TICK && phase_q == fpsl_pkg::PH_FINISH) begin
			if (cnt_q >= tgt_tmo) begin
				ph_n = fpsl_pkg::PH_TIMEOUT;
			end else if (conf_done_in) begin
				ph_n = fpsl_pkg::PH_DONE;
			end else begin
				kind_n = fpsl_pkg::CMD_PULSE;
				dclk_n = 1'b0;
				cnt_n  = cnt_q + 1'b1;
			end
		end

		// skip every finished part of the pulse (zero-length parts too)
		if (settle) begin
			for (int i = 0; i < 3; i++) begin
				case (sub_n)
					fpsl_pkg::SUB_HIGH:    tgt = tgt_high;
					fpsl_pkg::SUB_LOW:     tgt = tgt_low;
					default:               tgt = tgt_rec;
				endcase
				if (sub_n != fpsl_pkg::SUB_END && cnt_n >= tgt) begin
					sub_n = sub_n + 2'd1;
					cnt_n = '0;
				end
			end
			nc_n = (sub_n != fpsl_pkg::SUB_LOW);
			if (sub_n == fpsl_pkg::SUB_END)
				ph_n = fpsl_pkg::PH_WAIT;
		end
	end

	always_comb begin
		cmd.kind      = kind_n;
		cmd.data_byte = data_byte;
		cmd.dclk      = dclk_n;
		cmd.data0     = d0_n;
		cmd.nconfig   = nc_n;
		cmd.phase     = ph_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= fpsl_pkg::PH_IDLE;
			sub_q     <= fpsl_pkg::SUB_HIGH;
			cnt_q     <= '0;
			dclk_q    <= 1'b0;
			data0_q   <= 1'b0;
			nconfig_q <= 1'b1;
		end else if (accept) begin
			phase_q   <= ph_n;
			sub_q     <= sub_n;
			cnt_q     <= cnt_n;
			dclk_q    <= dclk_n;
			data0_q   <= d0_n;
			nconfig_q <= nc_n;
		end
	end

endmodule

// File: rtl/core/fpsl_queue.sv
// ----------------------------------------------------------------------------
// fpsl_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module fpsl_queue #(
	parameter int DEPTH = fpsl_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fpsl_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output fpsl_pkg::cmd_t pop_data,
	output logic           not_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	fpsl_pkg::cmd_t mem_q [DEPTH];
	logic [AW:0]    wptr_q;
	logic [AW:0]    rptr_q;

	assign full      = (wptr_q[AW] != rptr_q[AW]) && (wptr_q[AW-1:0] == rptr_q[AW-1:0]);
	assign not_empty = (wptr_q != rptr_q);
	assign pop_data  = mem_q[rptr_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wptr_q[AW-1:0]] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (push && !full)
				wptr_q <= wptr_q + 1'b1;
			if (pop && not_empty)
				rptr_q <= rptr_q + 1'b1;
		end
	end

endmodule

// File: rtl/core/fpsl_back.sv
// ----------------------------------------------------------------------------
// fpsl_back
// Expands commands into pin-state results, one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module fpsl_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  fpsl_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           dclk_out,
	output logic           data0_out,
	output logic           nconfig_out,
	output logic [2:0]     phase,
	output logic           last_of_run
);

	fpsl_pkg::cmd_t cur_q;
	logic           busy_q;
	logic [4:0]     step_q;
	logic [4:0]     last_step;
	logic           advance;
	logic           load;

	always_comb begin
		case (cur_q.kind)
			fpsl_pkg::CMD_BYTE:  last_step = fpsl_pkg::BYTE_LAST_STEP;
			fpsl_pkg::CMD_PULSE: last_step = fpsl_pkg::PULSE_LAST_STEP;
			default:             last_step = '0;
		endcase
	end

	assign last_of_run = (step_q == last_step);
	assign out_valid   = busy_q;
	assign advance     = busy_q && out_ready;
	assign load        = !busy_q || (advance && last_of_run);
	assign cmd_pop     = load && cmd_valid;

	// byte burst: even steps put the bit with DCLK low, odd steps raise DCLK,
	// the closing step drops DCLK and keeps the last bit
	always_comb begin
		dclk_out    = cur_q.dclk;
		data0_out   = cur_q.data0;
		nconfig_out = cur_q.nconfig;
		phase       = cur_q.phase;
		case (cur_q.kind)
			fpsl_pkg::CMD_BYTE: begin
				if (step_q == fpsl_pkg::BYTE_LAST_STEP) begin
					dclk_out  = 1'b0;
					data0_out = cur_q.data_byte[fpsl_pkg::BYTE_BITS-1];
				end else begin
					dclk_out  = step_q[0];
					data0_out = cur_q.data_byte[step_q[3:1]];
				end
			end
			fpsl_pkg::CMD_PULSE: dclk_out = (step_q == '0);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load && cmd_valid)
			cur_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (load) begin
			busy_q <= cmd_valid;
			step_q <= '0;
		end else if (advance) begin
			step_q <= step_q + 5'd1;
		end
	end

endmodule

// File: rtl/core/fpga_passive_serial_loader.sv
// ----------------------------------------------------------------------------
// fpga_passive_serial_loader
// Passive-serial FPGA configuration sequencer with stream ports and APB setup.
// ----------------------------------------------------------------------------
// Each input transfer carries a mode (tick, start, data byte, end of data)
// plus the sampled nSTATUS and CONF_DONE pins; each output transfer is one
// pin state (DCLK, DATA0, nCONFIG) with the current phase, and tlast marks
// the final state caused by an input item. A start runs the nCONFIG pulse
// (high, low, high, lengths counted in ticks), ticks then wait for nSTATUS,
// each data byte goes out LSB first as 17 states, and after end of data each
// tick either reports done, gives one more DCLK pulse, or reports timeout.
// Each state is one output transfer: most items give one state, a finishing
// tick that pulses DCLK gives 2 and a data byte 17. The back-end expander
// gives one pin state per cycle unless m_tready stalls it. Items are taken
// every cycle while the two-entry command queue has room, so input keeps
// flowing while a result waits on the output.
// Registers (APB, byte address 4*i): 0 pulse_high_ticks, 1 pulse_low_ticks,
// 2 recover_ticks, 3 done_timeout, 16 bits each; write only while idle.
// ----------------------------------------------------------------------------
module fpga_passive_serial_loader #(
	parameter int COUNT_BITS = fpsl_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] data_byte, [8] nstatus_in, [9] conf_done_in
	input  logic [1:0]  s_tuser,  // [1:0] mode
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [0] dclk_out, [1] data0_out, [2] nconfig_out, [5:3] phase
	output logic        m_tlast   // last_of_run
);

	fpsl_pkg::cfg_t cfg_q;
	fpsl_pkg::cmd_t f_cmd;
	fpsl_pkg::cmd_t q_cmd;
	logic           f_push;
	logic           q_full;
	logic           q_valid;
	logic           b_pop;
	logic           wr_en;
	logic           dclk_w;
	logic           data0_w;
	logic           nconfig_w;
	logic [2:0]     phase_w;

	// ---- configuration registers ----
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_high_ticks <= fpsl_pkg::PULSE_HIGH_RST;
			cfg_q.pulse_low_ticks  <= fpsl_pkg::PULSE_LOW_RST;
			cfg_q.recover_ticks    <= fpsl_pkg::RECOVER_RST;
			cfg_q.done_timeout     <= fpsl_pkg::DONE_TMO_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				fpsl_pkg::REG_PULSE_HIGH: cfg_q.pulse_high_ticks <= pwdata[15:0];
				fpsl_pkg::REG_PULSE_LOW:  cfg_q.pulse_low_ticks  <= pwdata[15:0];
				fpsl_pkg::REG_RECOVER:    cfg_q.recover_ticks    <= pwdata[15:0];
				fpsl_pkg::REG_DONE_TMO:   cfg_q.done_timeout     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			fpsl_pkg::REG_PULSE_HIGH: prdata = {16'd0, cfg_q.pulse_high_ticks};
			fpsl_pkg::REG_PULSE_LOW:  prdata = {16'd0, cfg_q.pulse_low_ticks};
			fpsl_pkg::REG_RECOVER:    prdata = {16'd0, cfg_q.recover_ticks};
			fpsl_pkg::REG_DONE_TMO:   prdata = {16'd0, cfg_q.done_timeout};
			default:                  prdata = '0;
		endcase
	end

	// ---- front end: sequence state, one command per accepted item ----
	fpsl_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.mode        (s_tuser),
		.data_byte   (s_tdata[7:0]),
		.nstatus_in  (s_tdata[8]),
		.conf_done_in(s_tdata[9]),
		.cmd_push    (f_push),
		.cmd         (f_cmd),
		.queue_full  (q_full)
	);

	// ---- command queue decouples the two ends ----
	fpsl_queue #(
		.DEPTH(fpsl_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push),
		.push_data(f_cmd),
		.full     (q_full),
		.pop      (b_pop),
		.pop_data (q_cmd),
		.not_empty(q_valid)
	);

	// ---- back end: expands commands into pin states ----
	fpsl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_valid),
		.cmd        (q_cmd),
		.cmd_pop    (b_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.dclk_out   (dclk_w),
		.data0_out  (data0_w),
		.nconfig_out(nconfig_w),
		.phase      (phase_w),
		.last_of_run(m_tlast)
	);

	assign m_tdata = {2'b00, phase_w, nconfig_w, data0_w, dclk_w};

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the passive-serial FPGA loader.
// ----------------------------------------------------------------------------
// A directed table walks a full configuration run and a restart: idle
// echoes, the nCONFIG pulse, nSTATUS wait, byte loads, and finish by
// timeout and by CONF_DONE. Random runs under several register settings
// follow, and a last run starts a pulse whose high part is set to the full
// 16-bit count. Each output transfer is checked field by field against a
// pin-state predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int          ITEMS_PER_PHASE = 16;
	localparam int          RX_HOLD_CYCLES  = 200;
	localparam int          DRAIN_SLACK     = 4;
	localparam int          TAIL_CYCLES     = 20;
	localparam longint      LIMIT_TIME      = 2_000_000;
	localparam logic [15:0] COUNT_MAX       = '1;

	// one output transfer: driven pins, phase and the end-of-item mark
	typedef struct packed {
		logic       dclk;
		logic       data0;
		logic       nconfig;
		logic [2:0] phase;
		logic       last;
	} pin_state_t;

	// one row of the directed table; want is used only where typed is set
	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] payload;
		logic       nstatus;
		logic       cdone;
		logic       typed;
		pin_state_t want;
	} stim_row_t;

	localparam pin_state_t NO_WANT = '0;

	// Directed run, with pulse_high 0, pulse_low 2, recover 1, done_timeout 1.
	// Typed rows are the idle echoes after reset and the two ways a run ends.
	localparam stim_row_t DIRECTED_ROWS [26] = '{
		// idle: everything but a start just echoes the reset pins
		'{fpsl_pkg::MODE_TICK,  8'h00, 1'b1, 1'b1, 1'b1,
			'{1'b0, 1'b0, 1'b1, fpsl_pkg::PH_IDLE, 1'b1}},
		'{fpsl_pkg::MODE_BYTE,  8'hFF, 1'b1, 1'b0, 1'b1,
			'{1'b0, 1'b0, 1'b1, fpsl_pkg::PH_IDLE, 1'b1}},
		'{fpsl_pkg::MODE_END,   8'h00, 1'b0, 1'b1, 1'b1,
			'{1'b0, 1'b0, 1'b1, fpsl_pkg::PH_IDLE, 1'b1}},
		// start: zero-length high part is skipped, nCONFIG goes low at once
		'{fpsl_pkg::MODE_START, 8'h5A, 1'b0, 1'b0, 1'b0, NO_WANT},
		// start while pulsing is ignored
		'{fpsl_pkg::MODE_START, 8'h00, 1'b1, 1'b1, 1'b0, NO_WANT},
		'{fpsl_pkg::MODE_TICK,  8'h00, 1'b0, 1'b0, 1'b0, NO_WANT},
		'{fpsl_pkg::MODE_TICK,  8'h00, 1'b1, 1'b0, 1'b0, NO_WANT},
		// recover part ends, wait for nSTATUS begins
		'{fpsl_pkg::MODE_TICK,  8'h00, 1'b0, 1'b1, 1'b0, NO_WANT},
		'{fpsl_pkg::MODE_TICK,  8'h00, 1'b0, 1'b0, 1'b0, NO_WANT},
		'{fpsl_pkg::MODE_BYTE,  8'h3C, 1'b1, 1'b1, 1'b0, NO_WANT},
		'{fpsl_pkg::MODE_TICK,  8'h00, 1'b1, 1'b0, 1'b0, NO_WANT},
		// loading: all-zero, all-one and mixed bytes
		'{fpsl_pkg::MODE_BYTE,  8'h00, 1'b0, 1'b0, 1'b0, NO_WANT},
		'{fpsl_pkg::MODE_BYTE,  8'hFF, 1'b1, 1'b1, 1'b0, NO_WANT},
		'{fpsl_pkg::MODE_BYTE,  8'hA5, 1'b0, 1'b0, 1'b0, NO_WANT},
		'{fpsl_pkg::MODE_TICK,  8'h00, 1'b1, 1'b1, 1'b0, NO_WANT},
		'{fpsl_pkg::MODE_END,   8'h00, 1'b0, 1'b0, 1'b0, NO_WANT},
		'{fpsl_pkg::MODE_END,   8'h00, 1'b1, 1'b1, 1'b0, NO_WANT},
		// finish: one extra DCLK pulse, then timeout wins over CONF_DONE
		'{fpsl_pkg::MODE_TICK,  8'h00, 1'b0, 1'b0, 1'b0, NO_WANT},
		'{fpsl_pkg::MODE_TICK,  8'h00, 1'b0, 1'b1, 1'b1,
			'{1'b0, 1'b1, 1'b1, fpsl_pkg::PH_TIMEOUT, 1'b1}},
		// restart from timeout; nSTATUS on the tick that ends the pulse is not looked at
		'{fpsl_pkg::MODE_START, 8'h00, 1'b0, 1'b0, 1'b0, NO_WANT},
		'{fpsl_pkg::MODE_TICK,  8'h00, 1'b0, 1'b0, 1'b0, NO_WANT},
		'{fpsl_pkg::MODE_TICK,  8'h00, 1'b0, 1'b0, 1'b0, NO_WANT},
		'{fpsl_pkg::MODE_TICK,  8'h00, 1'b1, 1'b0, 1'b0, NO_WANT},
		'{fpsl_pkg::MODE_TICK,  8'h00, 1'b1, 1'b0, 1'b0, NO_WANT},
		'{fpsl_pkg::MODE_END,   8'h00, 1'b0, 1'b0, 1'b0, NO_WANT},
		// CONF_DONE seen before the timeout count
		'{fpsl_pkg::MODE_TICK,  8'h00, 1'b0, 1'b1, 1'b1,
			'{1'b0, 1'b1, 1'b1, fpsl_pkg::PH_DONE, 1'b1}}
	};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;  // [7:0] data_byte, [8] nstatus_in, [9] conf_done_in
	logic [1:0]  s_tuser  = '0;  // [1:0] mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // [0] dclk_out, [1] data0_out, [2] nconfig_out, [5:3] phase
	logic        m_tlast;

	fpga_passive_serial_loader u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state: register mirror, sequence phase, pulse part, counter, pins
	fpsl_pkg::cfg_t cfg = '{fpsl_pkg::PULSE_HIGH_RST, fpsl_pkg::PULSE_LOW_RST,
		fpsl_pkg::RECOVER_RST, fpsl_pkg::DONE_TMO_RST};
	logic [2:0]  seq_phase   = fpsl_pkg::PH_IDLE;
	logic [1:0]  pulse_part  = fpsl_pkg::SUB_HIGH;
	logic [15:0] seq_count   = '0;
	logic        drv_dclk    = 1'b0;
	logic        drv_data0   = 1'b0;
	logic        drv_nconfig = 1'b1;

	pin_state_t  pin_state_q[$];  // pin states still owed by the block
	bit          typed_row  = 1'b0;  // directed row supplies its own expectation
	bit          idle_on    = 1'b1;  // random gaps on both streams
	int          hold_req   = 0;     // bumped to ask the receiver for a long hold
	int          hold_seen  = 0;
	int          fail_count = 0;

	function automatic void flag_failure(string msg);
		if (fail_count < 10)
			$display("[%0t] MISMATCH %s", $time, msg);
		fail_count++;
	endfunction

	function automatic void check_field(string what, int exp_v, int got_v);
		if (exp_v != got_v)
			flag_failure($sformatf("%s: expected %0d, got %0d", what, exp_v, got_v));
	endfunction

	function automatic logic [15:0] cfg_value(logic [1:0] idx);
		case (idx)
			fpsl_pkg::REG_PULSE_HIGH: return cfg.pulse_high_ticks;
			fpsl_pkg::REG_PULSE_LOW:  return cfg.pulse_low_ticks;
			fpsl_pkg::REG_RECOVER:    return cfg.recover_ticks;
			default:                  return cfg.done_timeout;
		endcase
	endfunction

	// ticks the current part of the nCONFIG pulse lasts
	function automatic logic [15:0] part_len(logic [1:0] part);
		case (part)
			fpsl_pkg::SUB_HIGH: return cfg.pulse_high_ticks;
			fpsl_pkg::SUB_LOW:  return cfg.pulse_low_ticks;
			default:            return cfg.recover_ticks;
		endcase
	endfunction

	task automatic log_pin_state(input bit fin);
		if (!typed_row)
			pin_state_q.push_back('{drv_dclk, drv_data0, drv_nconfig, seq_phase, fin});
	endtask

	// skip every part whose count is reached (zero-length parts included),
	// then drive nCONFIG for the part now running
	task automatic settle_nconfig();
		while (pulse_part != fpsl_pkg::SUB_END && seq_count >= part_len(pulse_part)) begin
			pulse_part++;
			seq_count = '0;
		end
		drv_nconfig = (pulse_part != fpsl_pkg::SUB_LOW);
		if (pulse_part == fpsl_pkg::SUB_END)
			seq_phase = fpsl_pkg::PH_WAIT;
	endtask

	// Pin states caused by one accepted item; acted is clear for an item
	// that the current phase ignores, which only echoes the pins.
	task automatic advance_sequencer(input logic [1:0] mode, input logic [7:0] payload,
			input logic nst, input logic cd, output bit acted);
		int b;
		acted = 1'b1;
		if (mode == fpsl_pkg::MODE_START && (seq_phase == fpsl_pkg::PH_IDLE ||
				seq_phase == fpsl_pkg::PH_DONE || seq_phase == fpsl_pkg::PH_TIMEOUT ||
				seq_phase == fpsl_pkg::PH_SPARE)) begin
			drv_dclk   = 1'b0;  // data0 keeps its level
			seq_phase  = fpsl_pkg::PH_PULSE;
			pulse_part = fpsl_pkg::SUB_HIGH;
			seq_count  = '0;
			settle_nconfig();
			log_pin_state(1'b1);
		end else if (mode == fpsl_pkg::MODE_TICK && seq_phase == fpsl_pkg::PH_PULSE) begin
			if (seq_count != COUNT_MAX)
				seq_count++;
			settle_nconfig();
			log_pin_state(1'b1);
		end else if (mode == fpsl_pkg::MODE_TICK && seq_phase == fpsl_pkg::PH_WAIT) begin
			if (nst) begin
				seq_phase = fpsl_pkg::PH_LOAD;
				seq_count = '0;
			end
			log_pin_state(1'b1);
		end else if (mode == fpsl_pkg::MODE_BYTE && seq_phase == fpsl_pkg::PH_LOAD) begin
			// LSB first: data with DCLK low, then DCLK high; closing DCLK low
			for (b = 0; b < fpsl_pkg::BYTE_BITS; b++) begin
				drv_data0 = payload[b];
				drv_dclk  = 1'b0;
				log_pin_state(1'b0);
				drv_dclk  = 1'b1;
				log_pin_state(1'b0);
			end
			drv_dclk = 1'b0;
			log_pin_state(1'b1);
		end else if (mode == fpsl_pkg::MODE_END && seq_phase == fpsl_pkg::PH_LOAD) begin
			seq_phase = fpsl_pkg::PH_FINISH;
			seq_count = '0;
			log_pin_state(1'b1);
		end else if (mode == fpsl_pkg::MODE_TICK && seq_phase == fpsl_pkg::PH_FINISH) begin
			// timeout is checked first, so it wins even with CONF_DONE high
			if (seq_count >= cfg.done_timeout) begin
				seq_phase = fpsl_pkg::PH_TIMEOUT;
				log_pin_state(1'b1);
			end else if (cd) begin
				seq_phase = fpsl_pkg::PH_DONE;
				log_pin_state(1'b1);
			end else begin
				drv_dclk = 1'b1;
				log_pin_state(1'b0);
				drv_dclk = 1'b0;
				seq_count++;
				log_pin_state(1'b1);
			end
		end else begin
			acted = 1'b0;
			log_pin_state(1'b1);
		end
	endtask

	// mostly the item the current phase wants, with random content; the rest is noise
	task automatic pick_random_item(output logic [1:0] mode, output logic [7:0] payload,
			output logic nst, output logic cd);
		int r;
		r       = $urandom_range(0, 99);
		payload = 8'($urandom);
		nst     = 1'($urandom);
		cd      = 1'($urandom);
		mode    = 2'($urandom_range(0, 3));
		case (seq_phase)
			fpsl_pkg::PH_IDLE, fpsl_pkg::PH_DONE, fpsl_pkg::PH_TIMEOUT: begin
				if (r < 75)
					mode = fpsl_pkg::MODE_START;
			end
			fpsl_pkg::PH_PULSE: begin
				if (r < 85)
					mode = fpsl_pkg::MODE_TICK;
			end
			fpsl_pkg::PH_WAIT: begin
				if (r < 85)
					mode = fpsl_pkg::MODE_TICK;
				nst = ($urandom_range(0, 2) == 0);
			end
			fpsl_pkg::PH_LOAD: begin
				if (r < 65)
					mode = fpsl_pkg::MODE_BYTE;
				else if (r < 80)
					mode = fpsl_pkg::MODE_END;
			end
			fpsl_pkg::PH_FINISH: begin
				if (r < 85)
					mode = fpsl_pkg::MODE_TICK;
				cd = ($urandom_range(0, 3) == 0);
			end
			default: ;
		endcase
	endtask

	// APB write: setup cycle, access cycle, then psel low again
	task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'h0000, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read(input logic [1:0] idx, output logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		val = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// write a register, update the mirror, read it back
	task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
		logic [31:0] rd;
		reg_write(idx, val);
		case (idx)
			fpsl_pkg::REG_PULSE_HIGH: cfg.pulse_high_ticks = val;
			fpsl_pkg::REG_PULSE_LOW:  cfg.pulse_low_ticks  = val;
			fpsl_pkg::REG_RECOVER:    cfg.recover_ticks    = val;
			default:                  cfg.done_timeout     = val;
		endcase
		reg_read(idx, rd);
		check_field($sformatf("register %0d readback", idx), cfg_value(idx), rd[15:0]);
	endtask

	task automatic set_all_regs(input logic [15:0] hi, input logic [15:0] lo,
			input logic [15:0] rc, input logic [15:0] tmo);
		set_reg(fpsl_pkg::REG_PULSE_HIGH, hi);
		set_reg(fpsl_pkg::REG_PULSE_LOW, lo);
		set_reg(fpsl_pkg::REG_RECOVER, rc);
		set_reg(fpsl_pkg::REG_DONE_TMO, tmo);
	endtask

	// Offer one item and hold it until transferred. A gap, when taken, comes
	// before the item, so tvalid is never dropped and raised in one step.
	task automatic send_item(input logic [1:0] mode, input logic [7:0] payload,
			input logic nst, input logic cd, output bit acted);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {6'd0, cd, nst, payload};
		do @(posedge clk); while (!s_tready);
		advance_sequencer(mode, payload, nst, cd, acted);
	endtask

	task automatic send_random(output bit acted);
		logic [1:0] md;
		logic [7:0] pl;
		logic       ns;
		logic       cdn;
		pick_random_item(md, pl, ns, cdn);
		send_item(md, pl, ns, cdn, acted);
	endtask

	// stop offering and let every owed pin state come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pin_state_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// Receiver: random short stalls, plus a long hold on request while the
	// sender keeps going, so the command queue fills and s_tready drops.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// output checker: oldest owed pin state against each output transfer
	always @(posedge clk) begin
		pin_state_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pin_state_q.size() == 0) begin
				flag_failure($sformatf("unexpected transfer tdata=%02h tlast=%0b",
					m_tdata, m_tlast));
			end else begin
				want = pin_state_q.pop_front();
				check_field("dclk", want.dclk, m_tdata[0]);
				check_field("data0", want.data0, m_tdata[1]);
				check_field("nconfig", want.nconfig, m_tdata[2]);
				check_field("phase", want.phase, m_tdata[5:3]);
				check_field("tlast", want.last, m_tlast);
			end
		end
	end

	initial begin
		logic [31:0] rd;
		stim_row_t   row;
		bit          acted;
		int          useful;
		int          n_sent;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers come out of reset at their default counts
		for (int i = 0; i < 4; i++) begin
			reg_read(2'(i), rd);
			check_field($sformatf("register %0d after reset", i), cfg_value(2'(i)), rd[15:0]);
		end

		// directed run with short pulse parts and a one-pulse timeout
		set_all_regs(16'd0, 16'd2, 16'd1, 16'd1);
		for (int i = 0; i < 26; i++) begin
			row       = DIRECTED_ROWS[i];
			typed_row = row.typed;
			send_item(row.mode, row.payload, row.nstatus, row.cdone, acted);
			if (row.typed)
				pin_state_q.push_back(row.want);
			typed_row = 1'b0;
		end

		// Random runs. Setting 0 is all zeros (every pulse part skipped,
		// immediate timeout); setting 2 has the largest timeout, so runs end
		// on CONF_DONE; the others are random and small.
		for (int p = 0; p < 4; p++) begin
			wait_drained();
			case (p)
				0: set_all_regs(16'd0, 16'd0, 16'd0, 16'd0);
				2: set_all_regs(16'd1, 16'd3, 16'd2, 16'hFFFF);
				default: set_all_regs(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
					16'($urandom_range(0, 3)), 16'($urandom_range(1, 4)));
			endcase
			useful = 0;
			n_sent = 0;
			while (useful < ITEMS_PER_PHASE) begin
				if (p == 2 && n_sent == 4)
					hold_req++;
				if (p == 3 && n_sent == 12)
					wait_drained();
				send_random(acted);
				n_sent++;
				if (acted)
					useful++;
			end
		end

		// last part: no idling; finish the current run, then start a pulse
		// with the high part at the full 16-bit count, which stays high
		idle_on = 1'b0;
		while (!(seq_phase == fpsl_pkg::PH_IDLE || seq_phase == fpsl_pkg::PH_DONE ||
				seq_phase == fpsl_pkg::PH_TIMEOUT))
			send_random(acted);
		wait_drained();
		set_all_regs(16'hFFFF, 16'd1, 16'd0, 16'd3);
		send_item(fpsl_pkg::MODE_START, 8'($urandom), 1'($urandom), 1'($urandom), acted);
		for (int i = 0; i < 20; i++)
			send_random(acted);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("fpga_passive_serial_loader regression: pass");
		else
			$display("fpga_passive_serial_loader regression: fail");
		$finish;
	end

	// hang guard
	initial begin
		#(LIMIT_TIME);
		$display("fpga_passive_serial_loader regression: fail");
		$finish;
	end

endmodule
